// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define SSBA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define SSBA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ssba_pkg.sv
package ssba_pkg;

    // slot map row geometry
    localparam int MAP_W  = 32;
    localparam int MAP_SH = 5;

    // fixed field widths
    localparam int SLOT_FW   = 10;
    localparam int SECTOR_FW = 13;
    localparam int ADDR_FW   = 32;
    localparam int CNT_FW    = 11;
    localparam int STATUS_FW = 2;

    // result status codes
    localparam logic [STATUS_FW-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_FW-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STATUS_FW-1:0] ST_NOTUSED = 2'd2;

    // request opcodes
    localparam logic OP_SWAP_OUT = 1'b0;
    localparam logic OP_SWAP_IN  = 1'b1;

    // register map
    localparam int                REG_SLOT_COUNT = 0;
    localparam logic [CNT_FW-1:0] SLOT_COUNT_RST = 11'd1024;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic rd;
        logic set_bit;
        logic clr_bit;
        logic next_row;
        logic emit_xfer;
        logic emit_err;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic req_bad;
        logic op;
        logic hit;
        logic scan_end;
        logic out_free;
        logic xfer_last;
    } t_stat;

endpackage

// File: hdl/ssba_ram.sv
module ssba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ssba_ctrl.sv
module ssba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  ssba_pkg::t_stat i_stat,
    output ssba_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_XFER = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.req_bad ? S_ERR : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_stat.hit) begin
                    if (i_stat.op == ssba_pkg::OP_SWAP_OUT) begin
                        o_cmd.set_bit = 1'b1;
                    end else begin
                        o_cmd.clr_bit = 1'b1;
                    end
                    n_state = S_XFER;
                end else if (i_stat.op == ssba_pkg::OP_SWAP_IN || i_stat.scan_end) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.next_row = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_XFER: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_xfer = 1'b1;
                    if (i_stat.xfer_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ssba_dp.sv
module ssba_dp #(
    parameter int MAX_SLOTS        = 1024,
    parameter int SECTORS_PER_PAGE = 8,
    parameter int SECTOR_BYTES     = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssba_pkg::t_cmd                     i_cmd,
    output ssba_pkg::t_stat                    o_stat,
    input  logic [ssba_pkg::CNT_FW-1:0]        i_slot_count,
    input  logic                               i_op,
    input  logic [ssba_pkg::SLOT_FW-1:0]       i_slot_index,
    input  logic [ssba_pkg::ADDR_FW-1:0]       i_page_address,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ssba_pkg::STATUS_FW-1:0]     o_status,
    output logic [ssba_pkg::SLOT_FW-1:0]       o_granted_slot,
    output logic [ssba_pkg::SECTOR_FW-1:0]     o_dev_sector,
    output logic [ssba_pkg::ADDR_FW-1:0]       o_buffer_address,
    output logic                               o_is_write,
    output logic                               o_last
);

    localparam int MAP_W  = ssba_pkg::MAP_W;
    localparam int BIT_W  = ssba_pkg::MAP_SH;
    localparam int ROWS   = (MAX_SLOTS + MAP_W - 1) / MAP_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_W + BIT_W;
    localparam int LIM_W  = $clog2(MAX_SLOTS + 1);
    localparam int OFF_W  = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;
    localparam int SLOT_FW   = ssba_pkg::SLOT_FW;
    localparam int SECTOR_FW = ssba_pkg::SECTOR_FW;
    localparam int ADDR_FW   = ssba_pkg::ADDR_FW;

    // request
    logic                 r_op;
    logic [SLOT_FW-1:0]   r_req;
    logic [BIT_W-1:0]     r_bit;
    logic [ADDR_FW-1:0]   r_page;

    // scan
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     r_hint;

    // transfer
    logic [IDX_W-1:0]     r_slot;
    logic [OFF_W-1:0]     r_off;
    logic [SECTOR_FW-1:0] r_sector;
    logic [ADDR_FW-1:0]   r_addr;

    // output word
    logic                          r_out_valid;
    logic [ssba_pkg::STATUS_FW-1:0] r_status;
    logic [SLOT_FW-1:0]            r_granted;
    logic [SECTOR_FW-1:0]          r_sector_out;
    logic [ADDR_FW-1:0]            r_addr_out;
    logic                          r_is_write;
    logic                          r_last;

    logic [31:0]          req_ext;
    logic [IDX_W-1:0]     req_idx;
    logic [LIM_W-1:0]     limit;
    logic [MAP_W-1:0]     rdata;
    logic [MAP_W-1:0]     wdata;
    logic [MAP_W-1:0]     elig;
    logic [MAP_W-1:0]     iso;
    logic [BIT_W-1:0]     enc;
    logic [IDX_W-1:0]     slot_n;
    logic                 ram_we;
    logic                 start_xfer;
    logic                 out_free;
    logic                 xfer_last;

    assign req_ext = 32'(i_slot_index);
    assign req_idx = req_ext[IDX_W-1:0];

    always_comb begin
        if (32'(i_slot_count) > 32'(MAX_SLOTS)) begin
            limit = LIM_W'(MAX_SLOTS);
        end else begin
            limit = LIM_W'(i_slot_count);
        end
    end

    // free slots of the current row that lie below the limit
    always_comb begin
        logic [IDX_W-1:0] b_idx;
        b_idx = '0;
        for (int b = 0; b < MAP_W; b++) begin
            b_idx   = {r_row, BIT_W'(b)};
            elig[b] = !rdata[b] && (32'(b_idx) < 32'(limit));
        end
    end

    // lowest eligible bit
    assign iso = elig & (~elig + MAP_W'(1));

    always_comb begin
        enc = '0;
        for (int b = 0; b < MAP_W; b++) begin
            if (iso[b]) begin
                enc = enc | BIT_W'(b);
            end
        end
    end

    assign slot_n     = (r_op == ssba_pkg::OP_SWAP_OUT) ? {r_row, enc} : {r_row, r_bit};
    assign start_xfer = i_cmd.set_bit | i_cmd.clr_bit;
    assign out_free   = !r_out_valid || i_m_tready;
    assign xfer_last  = (r_off == OFF_W'(SECTORS_PER_PAGE - 1));

    always_comb begin
        if (i_cmd.clr_wr) begin
            wdata = '0;
        end else if (i_cmd.set_bit) begin
            wdata = rdata | iso;
        end else begin
            wdata = rdata & ~(MAP_W'(1) << r_bit);
        end
    end

    assign ram_we = i_cmd.clr_wr | i_cmd.set_bit | i_cmd.clr_bit;

    ssba_ram #(
        .WIDTH(MAP_W),
        .DEPTH(ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_row),
        .o_rdata (rdata)
    );

    // row pointer and first-candidate hint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_hint <= '0;
        end else begin
            if (i_cmd.clr_wr && !o_stat.clr_done) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_cmd.accept) begin
                if (i_op == ssba_pkg::OP_SWAP_OUT) begin
                    r_row <= r_hint;
                end else begin
                    r_row <= req_idx[IDX_W-1:BIT_W];
                end
            end
            if (i_cmd.next_row) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_cmd.set_bit) begin
                r_hint <= r_row;
            end
            if (i_cmd.clr_bit && (r_row < r_hint)) begin
                r_hint <= r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_req  <= i_slot_index;
            r_bit  <= req_idx[BIT_W-1:0];
            r_page <= i_page_address;
        end
        if (start_xfer) begin
            r_slot   <= slot_n;
            r_off    <= '0;
            r_sector <= SECTOR_FW'(32'(slot_n) * SECTORS_PER_PAGE);
            r_addr   <= r_page;
        end
        if (i_cmd.emit_xfer) begin
            r_off    <= r_off + OFF_W'(1);
            r_sector <= r_sector + SECTOR_FW'(1);
            r_addr   <= r_addr + ADDR_FW'(SECTOR_BYTES);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_xfer || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_xfer) begin
            r_status     <= ssba_pkg::ST_OK;
            r_granted    <= SLOT_FW'(r_slot);
            r_sector_out <= r_sector;
            r_addr_out   <= r_addr;
            r_is_write   <= (r_op == ssba_pkg::OP_SWAP_OUT);
            r_last       <= xfer_last;
        end else if (i_cmd.emit_err) begin
            if (r_op == ssba_pkg::OP_SWAP_OUT) begin
                r_status  <= ssba_pkg::ST_NOFREE;
                r_granted <= '0;
            end else begin
                r_status  <= ssba_pkg::ST_NOTUSED;
                r_granted <= r_req;
            end
            r_sector_out <= '0;
            r_addr_out   <= '0;
            r_is_write   <= (r_op == ssba_pkg::OP_SWAP_OUT);
            r_last       <= 1'b1;
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_slot   = r_granted;
    assign o_dev_sector     = r_sector_out;
    assign o_buffer_address = r_addr_out;
    assign o_is_write       = r_is_write;
    assign o_last           = r_last;

    always_comb begin
        o_stat.clr_done  = (r_row == ROW_W'(ROWS - 1));
        o_stat.req_bad   = (i_op == ssba_pkg::OP_SWAP_IN) && (req_ext >= 32'(MAX_SLOTS));
        o_stat.op        = r_op;
        o_stat.hit       = (r_op == ssba_pkg::OP_SWAP_OUT) ? (|elig) : rdata[r_bit];
        o_stat.scan_end  = (32'({r_row, BIT_W'(0)}) + 32'(MAP_W)) >= 32'(limit);
        o_stat.out_free  = out_free;
        o_stat.xfer_last = xfer_last;
    end

endmodule

// File: hdl/swap_slot_bitmap_allocator_unit.sv
// swap slot allocator: first-fit bitmap of page-sized swap slots
// input stream (s_axis): one request word per swap-out or swap-in; opcode in tuser
// output stream (m_axis): one transfer command per sector, or a single error word;
//   tlast marks the final word of each request, tuser carries the write direction
// apb port: register 0 holds slot_count (11 bits, reset 1024, clamped to MAX_SLOTS)
// the map lives in a 32-bit-wide ram, one row per 32 slots; reset starts a clearing
//   pass that zeroes every row, with s_axis_tready low
// one request at a time: accept, then one ram read (RD) and check (CHK) per scanned row,
//   then one command word per cycle into the output register while the receiver keeps up
// swap in: after accept the sequencer passes through RD, CHK and XFER, and the first word
//   lands in the output register; swap out repeats RD and CHK for each row scanned past
//   the first row that may hold a free slot, since the ram is read one row at a time
// error words (no free slot, slot not in use) go out from S_ERR; a no-free word follows a
//   scan of each row from the first candidate row, and an out-of-range swap-in skips RD and CHK
// a stalled receiver holds the output register; the sequencer waits, nothing is dropped
// the next request is taken while the final word of the previous one still waits
module swap_slot_bitmap_allocator_unit #(
    parameter int MAX_SLOTS        = 1024,
    parameter int SECTORS_PER_PAGE = 8,
    parameter int SECTOR_BYTES     = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // slot_index[9:0], page_address[41:10], zero pad
    input  logic        s_axis_tuser,   // opcode
    // command stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // status[1:0], granted_slot[11:2],
                                        // dev_sector[24:12], buffer_address[56:25], pad
    output logic        m_axis_tuser,   // is_write
    output logic        m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ssba_pkg::CNT_FW-1:0]    r_slot_count;
    logic                           reg_hit;

    ssba_pkg::t_cmd                 cmd;
    ssba_pkg::t_stat                stat;

    logic [ssba_pkg::STATUS_FW-1:0] status;
    logic [ssba_pkg::SLOT_FW-1:0]   granted_slot;
    logic [ssba_pkg::SECTOR_FW-1:0] dev_sector;
    logic [ssba_pkg::ADDR_FW-1:0]   buffer_address;

    // register file: only slot_count, decoded from paddr[2]; addresses 4 to 7 read zero and ignore writes
    assign reg_hit = (paddr[2] == 1'(ssba_pkg::REG_SLOT_COUNT));
    assign pready  = 1'b1;
    assign prdata  = (psel && reg_hit) ? 32'(r_slot_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= ssba_pkg::SLOT_COUNT_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_slot_count <= pwdata[ssba_pkg::CNT_FW-1:0];
        end
    end

    // sequencer
    ssba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // slot map, scan, sector counter and output register
    ssba_dp #(
        .MAX_SLOTS        (MAX_SLOTS),
        .SECTORS_PER_PAGE (SECTORS_PER_PAGE),
        .SECTOR_BYTES     (SECTOR_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_slot_count     (r_slot_count),
        .i_op             (s_axis_tuser),
        .i_slot_index     (s_axis_tdata[9:0]),
        .i_page_address   (s_axis_tdata[41:10]),
        .o_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .o_status         (status),
        .o_granted_slot   (granted_slot),
        .o_dev_sector     (dev_sector),
        .o_buffer_address (buffer_address),
        .o_is_write       (m_axis_tuser),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, buffer_address, dev_sector, granted_slot, status};

endmodule

// File: hdl/ssba_chk.sv
`include "assert_macros.svh"

module ssba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] i_m_tdata,
    input logic        i_m_tuser,
    input logic        i_m_tlast
);

    // one request in flight: ready drops right after an accept
    `SSBA_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready, "request accepted while busy")

    // any error word closes its request
    `SSBA_ASSERT_NOW(a_err_last, i_clk, i_rst_n, i_m_tvalid && (i_m_tdata[1:0] != ssba_pkg::ST_OK), i_m_tlast, "error word without last")

    // no free slot: all fields zero, write direction
    `SSBA_ASSERT_NOW(a_nofree_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tdata[1:0] == ssba_pkg::ST_NOFREE), (i_m_tdata[56:2] == 55'd0) && i_m_tuser, "no-free word has payload")

    // stalled word holds
    `SSBA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "stalled word changed")

endmodule

bind swap_slot_bitmap_allocator_unit ssba_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
